// File: src/xcr_pkg.sv
// ----------------------------------------------------------------------------
// xcr_pkg
// Shared types and codes for the XMODEM checksum receiver.
// ----------------------------------------------------------------------------
package xcr_pkg;

    localparam int unsigned PAYLOAD_BYTES_DEF = 128;

    localparam int unsigned OFFSET_W = 15;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned LEN_W    = 16;

    localparam logic [7:0] CODE_ACK = 8'h06;
    localparam logic [7:0] CODE_NAK = 8'h15;
    localparam logic [7:0] CODE_EOT = 8'h04;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_word;

    typedef struct packed {
        logic                result_kind;
        logic [OFFSET_W-1:0] write_offset;
        logic [WORD_W-1:0]   write_word;
        logic [7:0]          reply_byte;
        logic                last;
        logic                busy_res;
    } t_out_word;

    typedef enum logic [1:0] {
        V_NONE,
        V_REPLY,
        V_WRITE
    } t_verdict;

    typedef struct packed {
        logic accept;
        logic load_word;
        logic load_ack;
        logic word_inc;
    } t_xcr_cmd;

    typedef struct packed {
        t_verdict verdict;
        logic     last_word;
    } t_xcr_sts;

endpackage

// File: src/xcr_ram.sv
// ----------------------------------------------------------------------------
// xcr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module xcr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/xcr_datapath.sv
// ----------------------------------------------------------------------------
// xcr_datapath
// Frame counter, checksum, payload buffer, frame verdict and result register.
// ----------------------------------------------------------------------------
module xcr_datapath
    import xcr_pkg::*;
#(
    parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [LEN_W-1:0] i_cfg_wr_data,
    input  t_in_word         i_in_word,
    input  t_xcr_cmd         i_cmd,
    output t_xcr_sts         o_sts,
    output t_out_word        o_out_word
);

    localparam int unsigned FRAME_BYTES = PAYLOAD_BYTES + 4;
    localparam int unsigned CNT_W       = $clog2(FRAME_BYTES + 2);
    localparam int unsigned WORDS       = PAYLOAD_BYTES / 4;
    localparam int unsigned WA_W        = $clog2(WORDS);
    localparam int unsigned LIM_W       = 8 + $clog2(PAYLOAD_BYTES + 1);

    localparam logic [CNT_W-1:0] CNT_DATA_LO = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_DATA_HI = CNT_W'(PAYLOAD_BYTES + 3);
    localparam logic [CNT_W-1:0] CNT_FRAME   = CNT_W'(FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_WORDS   = CNT_W'(WORDS * 4);
    localparam logic [WA_W-1:0]  WA_LAST     = WA_W'(WORDS - 1);
    localparam logic [LIM_W-1:0] LIM_PAYLOAD = LIM_W'(PAYLOAD_BYTES);

    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_first;
    logic [7:0]       r_blk;
    logic [7:0]       r_sum;
    logic             r_busy;
    logic [LEN_W-1:0] r_file_len;
    logic [WA_W-1:0]  r_k;
    logic [23:0]      r_shift;
    t_out_word        r_out;

    logic [CNT_W-1:0] n_count;
    logic [7:0]       n_first;
    logic [7:0]       n_blk;
    logic [7:0]       n_sum;
    logic             n_busy;
    logic [CNT_W-1:0] data_idx;
    logic             in_data;
    logic             ram_we;
    logic [WORD_W-1:0] ram_rdata;
    logic [LIM_W-1:0] blk_lim;
    logic [LIM_W-1:0] off_full;
    t_verdict         verdict;
    logic [7:0]       reply_code;
    logic [7:0]       b;

    assign b        = i_in_word.rx_byte;
    assign data_idx = r_count - CNT_DATA_LO;
    assign in_data  = (r_count >= CNT_DATA_LO) && (r_count < CNT_DATA_HI);
    assign ram_we   = i_cmd.accept && !i_in_word.command && in_data
                      && (data_idx[1:0] == 2'b11) && (data_idx < CNT_WORDS);

    xcr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (data_idx[WA_W+1:2]),
        .i_wdata ({b, r_shift}),
        .i_raddr (r_k),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_count    = (r_count <= CNT_FRAME) ? r_count + CNT_W'(1) : r_count;
        n_first    = (r_count == '0) ? b : r_first;
        n_blk      = (r_count == CNT_W'(1)) ? b : r_blk;
        n_sum      = in_data ? r_sum + b : r_sum;
        n_busy     = r_busy;
        blk_lim    = LIM_W'(n_blk) * LIM_PAYLOAD;
        verdict    = V_NONE;
        reply_code = CODE_NAK;
        if (i_in_word.command) begin
            n_busy  = 1'b1;
            verdict = V_REPLY;
        end else if (i_in_word.frame_end) begin
            if (n_count == CNT_FRAME) begin
                if (n_sum == b) begin
                    reply_code = CODE_ACK;
                    if ((n_blk != 8'd0) && (LIM_W'(r_file_len) >= blk_lim)) begin
                        verdict = V_WRITE;
                    end else begin
                        verdict = V_REPLY;
                    end
                end else begin
                    verdict = V_REPLY;
                end
            end else if (n_first == CODE_EOT) begin
                n_busy     = 1'b0;
                reply_code = CODE_ACK;
                verdict    = V_REPLY;
            end
        end
    end

    assign off_full = LIM_W'(r_blk - 8'd1) * LIM_PAYLOAD + LIM_W'({r_k, 2'b00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_first    <= '0;
            r_blk      <= '0;
            r_sum      <= '0;
            r_busy     <= 1'b0;
            r_file_len <= '0;
            r_k        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_file_len <= i_cfg_wr_data;
            end
            if (i_cmd.accept) begin
                r_k    <= '0;
                r_busy <= n_busy;
                if (!i_in_word.command) begin
                    r_first <= n_first;
                    r_blk   <= n_blk;
                    if (i_in_word.frame_end) begin
                        r_count <= '0;
                        r_sum   <= '0;
                    end else begin
                        r_count <= n_count;
                        r_sum   <= n_sum;
                    end
                end
            end else if (i_cmd.word_inc) begin
                r_k <= r_k + WA_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !i_in_word.command && in_data) begin
            r_shift <= {b, r_shift[23:8]};
        end
        if (i_cmd.accept && (verdict == V_REPLY)) begin
            r_out <= '{result_kind: KIND_REPLY, write_offset: '0, write_word: '0,
                       reply_byte: reply_code, last: 1'b1, busy_res: n_busy};
        end else if (i_cmd.load_word) begin
            r_out <= '{result_kind: KIND_WRITE, write_offset: off_full[OFFSET_W-1:0],
                       write_word: ram_rdata, reply_byte: 8'd0, last: 1'b0,
                       busy_res: r_busy};
        end else if (i_cmd.load_ack) begin
            r_out <= '{result_kind: KIND_REPLY, write_offset: '0, write_word: '0,
                       reply_byte: CODE_ACK, last: 1'b1, busy_res: r_busy};
        end
    end

    assign o_sts.verdict   = verdict;
    assign o_sts.last_word = (r_k == WA_LAST);
    assign o_out_word      = r_out;

endmodule

// File: src/xcr_ctrl.sv
// ----------------------------------------------------------------------------
// xcr_ctrl
// Sequencer for input acceptance, the word write burst and result handoff.
// ----------------------------------------------------------------------------
module xcr_ctrl
    import xcr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_xcr_sts i_sts,
    output t_xcr_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_SEND,
        S_LAST
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   n_in_stall;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && !r_in_stall) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_sts.verdict)
                        V_REPLY: begin
                            n_out_valid = 1'b1;
                            n_state     = S_LAST;
                        end
                        V_WRITE: n_state = S_FETCH;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_FETCH: n_state = S_LOAD;
            S_LOAD: begin
                o_cmd.load_word = 1'b1;
                n_out_valid     = 1'b1;
                n_state         = S_SEND;
            end
            S_SEND: begin
                if (!i_out_stall) begin
                    if (i_sts.last_word) begin
                        o_cmd.load_ack = 1'b1;
                        n_state        = S_LAST;
                    end else begin
                        o_cmd.word_inc = 1'b1;
                        n_out_valid    = 1'b0;
                        n_state        = S_FETCH;
                    end
                end
            end
            S_LAST: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_in_stall = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_stall  <= n_in_stall;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

endmodule

// File: src/xmodem_checksum_receiver_unit.sv
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver_unit
// XMODEM checksum receiver: frames, checks and stores 128-byte blocks.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): one word per received UART byte,
// or a start command. Output channel (o_out_valid / i_out_stall): file word
// writes and ACK/NAK reply bytes; last marks the final result of an input.
// i_cfg_wr_en / i_cfg_wr_data load file_length.
// A reply is registered and valid in the cycle after its input is accepted. A byte
// with no result leaves the input free for the next word; an input with a reply
// holds off further input until the reply is taken. A good stored block streams
// PAYLOAD_BYTES/4 words, each by RAM read, load and handoff, then the ACK.
// While results are pending o_in_stall is high; a stalled result holds its
// value. Reset clears the frame counter, checksum, busy flag and file_length
// and returns to idle; the payload RAM keeps no reset state.
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver_unit
    import xcr_pkg::*;
#(
    parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [LEN_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out_word
);

    t_xcr_cmd cmd;
    t_xcr_sts sts;

    xcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    xcr_datapath #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_word     (i_in_word),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_word    (o_out_word)
    );

endmodule

// File: tb/sv/xcr_frame_checker.sv
// ----------------------------------------------------------------------------
// xcr_frame_checker
// Watches both channels of the XMODEM checksum receiver and checks its results.
// Every accepted input word runs through a local copy of the frame state. The
// word writes and replies that the word should cause are queued. Each accepted
// output word is compared with the oldest queued result, and mismatches are
// counted for the testbench top.
// ----------------------------------------------------------------------------
module xcr_frame_checker
    import xcr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [LEN_W-1:0] i_cfg_wr_data,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in_word         i_in_word,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out_word        i_out_word,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results_seen
);

    localparam int FRAME_LEN   = PAYLOAD_BYTES_DEF + 4;
    localparam int PRINT_LIMIT = 40;

    logic [LEN_W-1:0] file_length = '0;
    logic [7:0]       byte_count  = '0;
    logic [7:0]       frame_head  = '0;
    logic [7:0]       blk         = '0;
    logic [7:0]       sum         = '0;
    logic             busy        = 1'b0;
    logic [7:0]       payload [PAYLOAD_BYTES_DEF];
    t_out_word        expected_results [$];

    function automatic t_out_word reply_word(input logic [7:0] code);
        t_out_word r;
        r            = '0;
        r.result_kind = KIND_REPLY;
        r.reply_byte = code;
        r.last       = 1'b1;
        r.busy_res   = busy;
        return r;
    endfunction

    function automatic string show(input t_out_word r);
        return $sformatf("kind=%0d off=%0d word=%h reply=%h last=%0d busy=%0d",
                         r.result_kind, r.write_offset, r.write_word, r.reply_byte,
                         r.last, r.busy_res);
    endfunction

    task automatic absorb_rx_word(input t_in_word w);
        t_out_word   wr;
        logic [31:0] base;
        int          i;
        if (w.command) begin
            busy = 1'b1;
            expected_results.push_back(reply_word(CODE_NAK));
            return;
        end
        if (byte_count == 0) begin
            frame_head = w.rx_byte;
        end else if (byte_count == 1) begin
            blk = w.rx_byte;
        end else if (byte_count >= 3 && byte_count < 3 + PAYLOAD_BYTES_DEF) begin
            payload[byte_count - 8'd3] = w.rx_byte;
            sum = sum + w.rx_byte;
        end
        if (byte_count <= FRAME_LEN)
            byte_count++;
        if (!w.frame_end)
            return;
        if (byte_count == FRAME_LEN) begin
            if (sum == w.rx_byte) begin
                if (blk != 0 && 32'(file_length) >= 32'(blk) * PAYLOAD_BYTES_DEF) begin
                    base = (32'(blk) - 32'd1) * PAYLOAD_BYTES_DEF;
                    for (i = 0; i < PAYLOAD_BYTES_DEF; i += 4) begin
                        wr              = '0;
                        wr.result_kind  = KIND_WRITE;
                        wr.write_offset = OFFSET_W'(base + 32'(i));
                        wr.write_word   = {payload[i+3], payload[i+2], payload[i+1], payload[i]};
                        wr.busy_res     = busy;
                        expected_results.push_back(wr);
                    end
                end
                expected_results.push_back(reply_word(CODE_ACK));
            end else begin
                expected_results.push_back(reply_word(CODE_NAK));
            end
        end else if (frame_head == CODE_EOT) begin
            busy = 1'b0;
            expected_results.push_back(reply_word(CODE_ACK));
        end
        byte_count = '0;
        sum        = '0;
    endtask

    task automatic check_result(input t_out_word got);
        t_out_word want;
        o_results_seen++;
        if (expected_results.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= PRINT_LIMIT)
                $display("%0t: unexpected result, expected none, actual %s", $time, show(got));
            return;
        end
        want = expected_results.pop_front();
        if (got !== want) begin
            o_fail_count++;
            if (o_fail_count <= PRINT_LIMIT)
                $display("%0t: mismatch, expected %s, actual %s", $time, show(want), show(got));
        end
    endtask

    // inputs are taken first so that a same-edge result would still find its entry
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            file_length = '0;
            byte_count  = '0;
            frame_head  = '0;
            blk         = '0;
            sum         = '0;
            busy        = 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en)
                file_length = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall)
                absorb_rx_word(i_in_word);
            if (i_out_valid && !i_out_stall)
                check_result(i_out_word);
        end
        o_pending = expected_results.size();
    end

endmodule

// File: tb/sv/tb_xmodem_checksum_receiver_unit.sv
// ----------------------------------------------------------------------------
// tb_xmodem_checksum_receiver_unit
// Stimulus and verdict for the XMODEM checksum receiver.
// A directed start stores a good block with a start command inside it, then
// sends a one-byte EOT frame and a short frame. Short random frames and start
// commands follow with random idle bursts on both channels. A quiet tail sends
// one random full-length, overlong or short-by-one frame under a random
// file_length, then two more random events. The checker module compares every result.
// ----------------------------------------------------------------------------
module tb_xmodem_checksum_receiver_unit;
    import xcr_pkg::*;

    localparam int PAYLOAD       = PAYLOAD_BYTES_DEF;
    localparam int FRAME_LEN     = PAYLOAD + 4;
    localparam int SETTLE_CYCLES = 3 * PAYLOAD / 4 + 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int ITEMS         = 320;
    localparam int TAIL_ROOM     = FRAME_LEN + 24;
    localparam int FILL_RANDOM   = 0;
    localparam int FILL_ZERO     = 1;
    localparam int FILL_ONES     = 2;
    localparam int NO_CMD        = -1;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0] cfg_wr_data = '0;
    logic             in_valid    = 1'b0;
    logic             in_stall;
    t_in_word         in_word     = '0;
    logic             out_valid;
    logic             out_stall   = 1'b0;
    t_out_word        out_word;

    int fail_count;
    int pending;
    int results_seen;
    int items_sent   = 0;
    int frames_sent  = 0;
    int cfg_writes   = 0;
    int gap_odds     = 8;
    int stall_left   = 0;
    int free_left    = 0;
    bit steady_tail  = 1'b0;

    always #4 i_clk = ~i_clk;

    xmodem_checksum_receiver_unit #(
        .PAYLOAD_BYTES(PAYLOAD)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in_word    (in_word),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_word   (out_word)
    );

    xcr_frame_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_word     (in_word),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_word    (out_word),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results_seen(results_seen)
    );

    // receiver stall: random bursts, with long free stretches between
    always @(negedge i_clk) begin
        if (steady_tail) begin
            out_stall = 1'b0;
        end else if (stall_left > 0) begin
            out_stall = 1'b1;
            stall_left--;
        end else if (free_left > 0) begin
            out_stall = 1'b0;
            free_left--;
        end else if ($urandom_range(0, 3) == 0) begin
            out_stall = 1'b0;
            free_left = $urandom_range(20, 300);
        end else if ($urandom_range(0, 4) == 0) begin
            out_stall  = 1'b1;
            stall_left = $urandom_range(0, 17);
        end else begin
            out_stall = 1'b0;
        end
    end

    // called and returning at a falling edge
    task automatic put_word(input logic cmd, input logic [7:0] b, input logic fend);
        int gap;
        if (!steady_tail && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            gap      = $urandom_range(1, 18);
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_word  = {cmd, b, fend};
        in_valid = 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    // frame of len bytes; a start command is slipped in before byte cmd_pos
    task automatic send_frame(input logic [7:0] head, input logic [7:0] blk_num,
                              input int len, input int fill, input bit good_sum,
                              input int cmd_pos);
        logic [7:0] sum;
        logic [7:0] b;
        int         p;
        sum = '0;
        for (p = 0; p < len; p++) begin
            if (p == cmd_pos)
                put_word(1'b1, 8'($urandom), 1'($urandom));
            if (p == 0) begin
                b = head;
            end else if (p == 1) begin
                b = blk_num;
            end else if (p == 2) begin
                b = ~blk_num;
            end else if (p == len - 1 && len == FRAME_LEN) begin
                b = good_sum ? sum : sum + 8'($urandom_range(1, 255));
            end else begin
                case (fill)
                    FILL_ZERO: b = 8'h00;
                    FILL_ONES: b = 8'hFF;
                    default:   b = 8'($urandom);
                endcase
                if (p < 3 + PAYLOAD)
                    sum = sum + b;
            end
            put_word(1'b0, b, p == len - 1);
        end
        frames_sent++;
    endtask

    task automatic set_file_length(input logic [LEN_W-1:0] len);
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = len;
        @(negedge i_clk);
        cfg_wr_en = 1'b0;
        cfg_writes++;
    endtask

    // short frame, EOT frame or start command
    task automatic random_event();
        logic [7:0] blk_num;
        logic [7:0] head;
        int         sel;
        int         len;
        int         cmd_pos;
        sel      = $urandom_range(0, 99);
        blk_num  = 8'($urandom_range(0, 4));
        head     = ($urandom_range(0, 1) == 0) ? 8'h01 : 8'($urandom);
        gap_odds = ($urandom_range(0, 2) == 0) ? 0 : 8;
        if (sel < 25) begin
            len  = $urandom_range(1, 4);
            head = CODE_EOT;
        end else if (sel < 45) begin
            put_word(1'b1, 8'($urandom), 1'($urandom));
            return;
        end else begin
            len = $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0)
                head = CODE_EOT;
        end
        cmd_pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : NO_CMD;
        send_frame(head, blk_num, len, FILL_RANDOM, 1'b0, cmd_pos);
    endtask

    // full-length frame, or one that is overlong or one byte short
    task automatic random_full_frame();
        logic [7:0] blk_num;
        logic [7:0] head;
        int         sel;
        int         len;
        int         fill;
        sel     = $urandom_range(0, 9);
        blk_num = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        head    = ($urandom_range(0, 3) == 0) ? CODE_EOT : 8'h01;
        case ($urandom_range(0, 9))
            0:       fill = FILL_ZERO;
            1:       fill = FILL_ONES;
            default: fill = FILL_RANDOM;
        endcase
        if (sel == 0)
            len = $urandom_range(FRAME_LEN + 1, FRAME_LEN + 3);
        else if (sel == 1)
            len = FRAME_LEN - 1;
        else
            len = FRAME_LEN;
        send_frame(head, blk_num, len, fill, $urandom_range(0, 4) != 0, NO_CMD);
    endtask

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge i_rst_n);
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: timeout, %0d cycles with no word moving", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed
        set_file_length(16'd384);
        put_word(1'b1, 8'hFF, 1'b1);
        send_frame(8'h01, 8'd1, FRAME_LEN, FILL_RANDOM, 1'b1, 60);
        send_frame(CODE_EOT, 8'd0, 1, FILL_RANDOM, 1'b0, NO_CMD);
        send_frame(8'h01, 8'd9, 5, FILL_RANDOM, 1'b0, NO_CMD);

        // short random events, leaving room for the tail
        while (items_sent < ITEMS - TAIL_ROOM)
            random_event();

        // tail without idling
        steady_tail = 1'b1;
        case ($urandom_range(0, 4))
            0:       set_file_length(16'h0000);
            1:       set_file_length(16'hFFFF);
            2:       set_file_length(16'd127);
            3:       set_file_length(16'($urandom));
            default: set_file_length(16'($urandom_range(128, 640)));
        endcase
        random_full_frame();
        repeat (2) random_event();

        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Ran %0d input words in %0d frames across %0d file_length writes.",
                 items_sent, frames_sent, cfg_writes);
        $display("Checked %0d results, %0d mismatched.", results_seen, fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
